>>> rtl/session_ticket_cache_core_macros.svh
// ----------------------------------------------------------------------------
// session_ticket_cache_core_macros
// Assertion helpers shared by the ticket cache RTL.
// ----------------------------------------------------------------------------
`ifndef SESSION_TICKET_CACHE_CORE_MACROS_SVH
`define SESSION_TICKET_CACHE_CORE_MACROS_SVH

// same-cycle implication
`define SCT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Types, codes and defaults of the session ticket cache.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int ENTRIES_DEF     = 64;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int KEY_BITS_DEF    = 64;
   localparam int TICKET_BITS_DEF = 32;

   localparam int TIME_W = 48;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic [31:0] LIFETIME_RESET = 32'd600000000;
   localparam logic [6:0]  CAPACITY_RESET = 7'd50;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFETIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd1;

   // operation codes
   localparam logic OP_STORE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // status codes
   localparam logic [2:0] ST_STORED        = 3'd0;
   localparam logic [2:0] ST_FOUND         = 3'd1;
   localparam logic [2:0] ST_MISS          = 3'd2;
   localparam logic [2:0] ST_EXPIRED       = 3'd3;
   localparam logic [2:0] ST_EMPTY_REMOVED = 3'd4;
   localparam logic [2:0] ST_QUEUE_FULL    = 3'd5;
   localparam logic [2:0] ST_IGNORED       = 3'd6;

   typedef struct packed {
      logic              opcode;
      logic [63:0]       session_key;
      logic [31:0]       ticket_in;
      logic [7:0]        proto_ver;
      logic              acquire_ok;
      logic [TIME_W-1:0] time_now;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] ticket_out;
      logic        evicted;
   } rsp_type;

endpackage

>>> rtl/sct_ram.sv
// ----------------------------------------------------------------------------
// sct_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/session_ticket_cache_core.sv
// Flow: a store with a null ticket goes from acceptance straight to the response state;
// any other transaction walks the entry RAM and then applies, and a popped single-use ticket
// is read from the queue RAM before the response. One transaction at a time; the walk of
// the entry RAM issues one read per cycle.
// Reset: state, valid bits, entry count and handshakes clear and the configuration registers
// take their defaults; the RAMs are not scrubbed since every entry is written in full when it is created.
// ----------------------------------------------------------------------------
// session_ticket_cache_core
// Keyed ticket table: entry records in one RAM, single-use ticket queues in another.
// ----------------------------------------------------------------------------
module session_ticket_cache_core
   import sct_pkg::*;
#(
   parameter int ENTRIES     = ENTRIES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF,
   parameter int TICKET_BITS = TICKET_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

`include "session_ticket_cache_core_macros.svh"

   localparam int IW    = $clog2(ENTRIES);
   localparam int SW    = $clog2(ENTRIES + 1);
   localparam int QHW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
   localparam int TW    = (TICKET_BITS < 32) ? TICKET_BITS : 32;
   localparam int QAW   = $clog2(ENTRIES * QUEUE_DEPTH);
   localparam int CMPW  = (SW > 7) ? SW : 7;
   localparam int CNT_LO  = 0;
   localparam int HEAD_LO = QCW;
   localparam int REU_LO  = HEAD_LO + QHW;
   localparam int EXP_LO  = REU_LO + TW;
   localparam int KEY_LO  = EXP_LO + TIME_W;
   localparam int EW      = KEY_LO + KEY_BITS;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_APPLY = 5'b00100,
      S_QREAD = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [SW-1:0]        scan_ff, scan_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IW-1:0]        chk_idx_ff, chk_idx_in;
   req_type              req_ff, req_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [SW-1:0]        count_ff, count_in;
   logic [31:0]          lifetime_ff, lifetime_in;
   logic [6:0]           capacity_ff, capacity_in;
   logic                 hit_ff, hit_in;
   logic [IW-1:0]        hit_idx_ff, hit_idx_in;
   logic [EW-1:0]        hit_rec_ff, hit_rec_in;
   logic                 free_ok_ff, free_ok_in;
   logic [IW-1:0]        free_idx_ff, free_idx_in;
   logic                 old_ok_ff, old_ok_in;
   logic [IW-1:0]        old_idx_ff, old_idx_in;
   logic [TIME_W-1:0]    old_exp_ff, old_exp_in;
   logic                 exp_any_ff, exp_any_in;
   logic [IW-1:0]        exp_idx_ff, exp_idx_in;
   logic [ENTRIES-1:0]   exp_mask_ff, exp_mask_in;
   logic [SW-1:0]        exp_cnt_ff, exp_cnt_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 ent_we, ent_re;
   logic [IW-1:0]        ent_waddr, ent_raddr;
   logic [EW-1:0]        ent_wdata, ent_rdata;
   logic                 q_we, q_re;
   logic [QAW-1:0]       q_waddr, q_raddr;
   logic [TW-1:0]        q_wdata, q_rdata;

   // entry records
   sct_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   // single-use ticket queues, QUEUE_DEPTH slots per entry
   sct_ram #(.WIDTH(TW), .DEPTH(ENTRIES * QUEUE_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next-state logic
   always_comb begin
      logic [KEY_BITS-1:0] key_q;
      logic [TW-1:0]       tkt_q;
      logic                single_use;
      logic                rv;
      logic [KEY_BITS-1:0] r_key;
      logic [TIME_W-1:0]   r_exp;
      logic [IW-1:0]       e_idx;
      logic [IW-1:0]       slot_idx;
      logic [KEY_BITS-1:0] f_key;
      logic [TIME_W-1:0]   f_exp;
      logic [TW-1:0]       f_reu;
      logic [QHW-1:0]      f_head;
      logic [QCW-1:0]      f_cnt;
      logic [TIME_W:0]     exp_sum;
      logic [QCW:0]        qsum;
      logic [QHW-1:0]      qslot;
      logic [QHW-1:0]      head_nx;
      logic                evict;

      state_in     = state_ff;
      scan_in      = scan_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      req_in       = req_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      lifetime_in  = lifetime_ff;
      capacity_in  = capacity_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rec_in   = hit_rec_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      old_ok_in    = old_ok_ff;
      old_idx_in   = old_idx_ff;
      old_exp_in   = old_exp_ff;
      exp_any_in   = exp_any_ff;
      exp_idx_in   = exp_idx_ff;
      exp_mask_in  = exp_mask_ff;
      exp_cnt_in   = exp_cnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ent_we       = 1'b0;
      ent_re       = 1'b0;
      ent_waddr    = '0;
      ent_raddr    = scan_ff[IW-1:0];
      ent_wdata    = '0;
      q_we         = 1'b0;
      q_re         = 1'b0;
      q_waddr      = '0;
      q_raddr      = '0;
      q_wdata      = '0;

      key_q      = req_ff.session_key[KEY_BITS-1:0];
      tkt_q      = req_ff.ticket_in[TW-1:0];
      single_use = ((req_ff.proto_ver >= 8'd5) && (req_ff.proto_ver <= 8'd200))
                   || (req_ff.proto_ver > 8'd202);
      rv         = valid_ff[chk_idx_ff];
      r_key      = ent_rdata[KEY_LO +: KEY_BITS];
      r_exp      = ent_rdata[EXP_LO +: TIME_W];
      e_idx      = hit_idx_ff;
      slot_idx   = free_idx_ff;
      f_key      = hit_rec_ff[KEY_LO +: KEY_BITS];
      f_exp      = hit_rec_ff[EXP_LO +: TIME_W];
      f_reu      = hit_rec_ff[REU_LO +: TW];
      f_head     = hit_rec_ff[HEAD_LO +: QHW];
      f_cnt      = hit_rec_ff[CNT_LO +: QCW];
      exp_sum    = {1'b0, req_ff.time_now} + (TIME_W + 1)'(lifetime_ff);
      qsum       = '0;
      qslot      = '0;
      head_nx    = '0;
      evict      = 1'b0;

      // drain the result register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_valid) begin
         if (csr_index == CSR_LIFETIME) begin
            lifetime_in = csr_wdata;
         end else if (csr_index == CSR_CAPACITY) begin
            capacity_in = csr_wdata[6:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               scan_in     = '0;
               hit_in      = 1'b0;
               free_ok_in  = 1'b0;
               old_ok_in   = 1'b0;
               exp_any_in  = 1'b0;
               exp_mask_in = '0;
               exp_cnt_in  = '0;
               if (req_data.opcode == OP_STORE && req_data.ticket_in[TW-1:0] == '0) begin
                  res_in   = '{status: ST_IGNORED, ticket_out: 32'd0, evicted: 1'b0};
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue one entry read per cycle
            if (scan_ff < SW'(ENTRIES)) begin
               ent_re     = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[IW-1:0];
               scan_in    = scan_ff + 1'b1;
            end
            // check the entry read last cycle
            if (chk_vld_ff) begin
               if (!rv) begin
                  if (!free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
               end else begin
                  if (!hit_ff && r_key == key_q) begin
                     hit_in     = 1'b1;
                     hit_idx_in = chk_idx_ff;
                     hit_rec_in = ent_rdata;
                  end
                  if (!old_ok_ff || r_exp < old_exp_ff) begin
                     old_ok_in  = 1'b1;
                     old_idx_in = chk_idx_ff;
                     old_exp_in = r_exp;
                  end
                  if (req_ff.time_now > r_exp) begin
                     exp_mask_in[chk_idx_ff] = 1'b1;
                     exp_cnt_in              = exp_cnt_ff + 1'b1;
                     if (!exp_any_ff) begin
                        exp_any_in = 1'b1;
                        exp_idx_in = chk_idx_ff;
                     end
                  end
               end
               if (chk_idx_ff == IW'(ENTRIES - 1)) begin
                  state_in = S_APPLY;
               end
            end
         end
         S_APPLY: begin
            if (req_ff.opcode == OP_STORE) begin
               // create the entry when the key is new, cleaning up first if full
               if (!hit_ff) begin
                  if (CMPW'(count_ff) >= CMPW'(capacity_ff) || !free_ok_ff) begin
                     if (exp_any_ff) begin
                        valid_in = valid_in & ~exp_mask_ff;
                        count_in = count_in - exp_cnt_ff;
                        evict    = 1'b1;
                        if (!free_ok_ff || exp_idx_ff < free_idx_ff) begin
                           slot_idx = exp_idx_ff;
                        end
                     end else if (old_ok_ff) begin
                        valid_in[old_idx_ff] = 1'b0;
                        count_in = count_in - 1'b1;
                        evict    = 1'b1;
                        if (!free_ok_ff || old_idx_ff < free_idx_ff) begin
                           slot_idx = old_idx_ff;
                        end
                     end
                  end
                  e_idx           = slot_idx;
                  valid_in[e_idx] = 1'b1;
                  count_in        = count_in + 1'b1;
                  f_key  = key_q;
                  f_exp  = exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];
                  f_reu  = '0;
                  f_head = '0;
                  f_cnt  = '0;
               end
               res_in = '{status: ST_STORED, ticket_out: 32'd0, evicted: evict};
               if (single_use) begin
                  if (f_cnt >= QCW'(QUEUE_DEPTH)) begin
                     res_in.status = ST_QUEUE_FULL;
                  end else begin
                     qsum = (QCW + 1)'(f_head) + (QCW + 1)'(f_cnt);
                     if (qsum >= (QCW + 1)'(QUEUE_DEPTH)) begin
                        qsum = qsum - (QCW + 1)'(QUEUE_DEPTH);
                     end
                     qslot   = qsum[QHW-1:0];
                     q_we    = 1'b1;
                     q_waddr = QAW'(e_idx) * QAW'(QUEUE_DEPTH) + QAW'(qslot);
                     q_wdata = tkt_q;
                     f_cnt   = f_cnt + 1'b1;
                  end
               end else begin
                  f_reu = tkt_q;
               end
               ent_we    = 1'b1;
               ent_waddr = e_idx;
               ent_wdata = {f_key, f_exp, f_reu, f_head, f_cnt};
               state_in  = S_RESP;
            end else begin
               // lookup
               res_in   = '{status: ST_MISS, ticket_out: 32'd0, evicted: 1'b0};
               state_in = S_RESP;
               if (hit_ff) begin
                  if (req_ff.time_now > f_exp) begin
                     valid_in[e_idx] = 1'b0;
                     count_in        = count_in - 1'b1;
                     res_in.status   = ST_EXPIRED;
                  end else if (f_cnt != '0) begin
                     q_re    = 1'b1;
                     q_raddr = QAW'(e_idx) * QAW'(QUEUE_DEPTH) + QAW'(f_head);
                     head_nx = (f_head == QHW'(QUEUE_DEPTH - 1)) ? '0 : f_head + 1'b1;
                     ent_we    = 1'b1;
                     ent_waddr = e_idx;
                     ent_wdata = {f_key, f_exp, f_reu, head_nx, QCW'(f_cnt - 1'b1)};
                     state_in  = S_QREAD;
                  end else if (f_reu != '0 && req_ff.acquire_ok) begin
                     res_in = '{status: ST_FOUND, ticket_out: 32'(f_reu), evicted: 1'b0};
                  end else begin
                     valid_in[e_idx] = 1'b0;
                     count_in        = count_in - 1'b1;
                     res_in.status   = ST_EMPTY_REMOVED;
                  end
               end
            end
         end
         S_QREAD: begin
            // popped ticket arrives from the queue RAM
            res_in   = '{status: ST_FOUND, ticket_out: 32'(q_rdata), evicted: 1'b0};
            state_in = S_RESP;
         end
         S_RESP: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         lifetime_ff  <= LIFETIME_RESET;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         lifetime_ff  <= lifetime_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and search registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      req_ff      <= req_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rec_ff  <= hit_rec_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      old_ok_ff   <= old_ok_in;
      old_idx_ff  <= old_idx_in;
      old_exp_ff  <= old_exp_in;
      exp_any_ff  <= exp_any_in;
      exp_idx_ff  <= exp_idx_in;
      exp_mask_ff <= exp_mask_in;
      exp_cnt_ff  <= exp_cnt_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // checks
   `SCT_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != S_IDLE, "accepted transaction did not start")
   `SCT_ASSERT_IMPL(a_count_matches_valid, clock, reset, 1'b1, $countones(valid_ff) == int'(count_ff), "entry count disagrees with valid bits")
   `SCT_ASSERT_IMPL(a_qread_after_apply, clock, reset, state_ff == S_QREAD, $past(state_ff) == S_APPLY, "queue read without a lookup")

endmodule
